// ===== rtl/ltc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types, constants and character helpers for the token classifier.
// ----------------------------------------------------------------------------
package ltc_pkg;

	localparam int LENGTH_LIMIT_DEFAULT = 255;
	localparam int NUM_KW = 22;
	localparam int KW_MAXLEN = 8;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		KIND_KEYWORD  = 3'd0,
		KIND_INTEGER  = 3'd1,
		KIND_REAL     = 3'd2,
		KIND_IDENT    = 3'd3,
		KIND_INVALID  = 3'd4,
		KIND_OPERATOR = 3'd5
	} kind_t;

	typedef struct packed {
		logic       tok_valid;
		kind_t      tok_kind;
		logic [4:0] tok_kw;
		logic [7:0] tok_len;
		logic       op_valid;
		logic [7:0] op_char;
	} cmd_t;

	localparam logic [3:0] KW_LEN [0:NUM_KW-1] = '{
		4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4,
		4'd4, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4
	};

	localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:KW_MAXLEN-1] = '{
		'{0:"i", 1:"f", default:8'h00},
		'{0:"e", 1:"l", 2:"s", 3:"e", default:8'h00},
		'{0:"w", 1:"h", 2:"i", 3:"l", 4:"e", default:8'h00},
		'{0:"d", 1:"o", default:8'h00},
		'{0:"b", 1:"r", 2:"e", 3:"a", 4:"k", default:8'h00},
		'{"c", "o", "n", "t", "i", "n", "u", "e"},
		'{0:"i", 1:"n", 2:"t", default:8'h00},
		'{0:"d", 1:"o", 2:"u", 3:"b", 4:"l", 5:"e", default:8'h00},
		'{0:"f", 1:"l", 2:"o", 3:"a", 4:"t", default:8'h00},
		'{0:"r", 1:"e", 2:"t", 3:"u", 4:"r", 5:"n", default:8'h00},
		'{0:"c", 1:"h", 2:"a", 3:"r", default:8'h00},
		'{0:"c", 1:"a", 2:"s", 3:"e", default:8'h00},
		'{0:"s", 1:"i", 2:"z", 3:"e", 4:"o", 5:"f", default:8'h00},
		'{0:"l", 1:"o", 2:"n", 3:"g", default:8'h00},
		'{0:"s", 1:"h", 2:"o", 3:"r", 4:"t", default:8'h00},
		'{0:"t", 1:"y", 2:"p", 3:"e", 4:"d", 5:"e", 6:"f", default:8'h00},
		'{0:"s", 1:"w", 2:"i", 3:"t", 4:"c", 5:"h", default:8'h00},
		'{"u", "n", "s", "i", "g", "n", "e", "d"},
		'{0:"v", 1:"o", 2:"i", 3:"d", default:8'h00},
		'{0:"s", 1:"t", 2:"a", 3:"t", 4:"i", 5:"c", default:8'h00},
		'{0:"s", 1:"t", 2:"r", 3:"u", 4:"c", 5:"t", default:8'h00},
		'{0:"g", 1:"o", 2:"t", 3:"o", default:8'h00}
	};

	function automatic logic is_operator(input logic [7:0] c);
		logic r;
		case (c) inside
			"+", "-", "*", "/", "<", ">", "=": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_delimiter(input logic [7:0] c);
		logic r;
		case (c) inside
			"+", "-", "*", "/", "<", ">", "=",
			" ", ",", ";", "(", ")", "[", "]", "{", "}": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/ltc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_front
// Accepts source characters, tracks the pending token and classifies it.
// ----------------------------------------------------------------------------
module ltc_front import ltc_pkg::*; #(
	parameter int LENGTH_LIMIT = LENGTH_LIMIT_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] character,
	input  logic       end_of_text,
	input  logic       queue_full,
	output logic       in_stall,
	output logic       push,
	output cmd_t       push_cmd
);

	localparam int LenW = $clog2(LENGTH_LIMIT + 1);
	localparam int ExtW = (LenW > 8) ? LenW : 8;

	logic [LenW-1:0]   pending_q;
	logic [NUM_KW-1:0] cand_q;
	logic              all_digits_q;
	logic              dod_q;
	logic              seen_dot_q;
	logic              swd_q;

	logic              accept;
	logic              digit;
	logic              is_dot;
	logic              delim;
	logic              op;
	logic              closing;
	logic [ExtW-1:0]   len_ext;
	logic [NUM_KW-1:0] cand_next;
	logic              kw_hit;
	logic [4:0]        kw_idx;
	kind_t             tok_kind;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;
	assign digit    = (character >= "0") && (character <= "9");
	assign is_dot   = (character == ".");
	assign delim    = is_delimiter(character);
	assign op       = !end_of_text && is_operator(character);
	assign closing  = end_of_text || delim;
	assign len_ext  = ExtW'(pending_q);

	always_comb begin
		kw_hit = 1'b0;
		kw_idx = '0;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (cand_q[k] && len_ext == ExtW'(KW_LEN[k])) begin
				kw_hit = 1'b1;
				kw_idx = 5'(k);
			end
		end
		for (int k = 0; k < NUM_KW; k++) begin
			cand_next[k] = cand_q[k] && (len_ext < ExtW'(KW_LEN[k])) &&
				(KW_TEXT[k][len_ext[2:0]] == character);
		end
		if (kw_hit) begin
			tok_kind = KIND_KEYWORD;
		end else if (all_digits_q) begin
			tok_kind = KIND_INTEGER;
		end else if (dod_q && seen_dot_q) begin
			tok_kind = KIND_REAL;
		end else if (!swd_q) begin
			tok_kind = KIND_IDENT;
		end else begin
			tok_kind = KIND_INVALID;
		end
	end

	always_comb begin
		push_cmd.tok_valid = (pending_q != '0);
		push_cmd.tok_kind  = tok_kind;
		push_cmd.tok_kw    = kw_idx;
		push_cmd.tok_len   = (len_ext > ExtW'(255)) ? 8'hFF : len_ext[7:0];
		push_cmd.op_valid  = op;
		push_cmd.op_char   = op ? character : 8'h00;
	end

	assign push = accept && closing && (push_cmd.tok_valid || op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			cand_q       <= '1;
			all_digits_q <= 1'b1;
			dod_q        <= 1'b1;
			seen_dot_q   <= 1'b0;
			swd_q        <= 1'b0;
		end else if (accept) begin
			if (closing) begin
				pending_q    <= '0;
				cand_q       <= '1;
				all_digits_q <= 1'b1;
				dod_q        <= 1'b1;
				seen_dot_q   <= 1'b0;
				swd_q        <= 1'b0;
			end else begin
				cand_q <= cand_next;
				if (pending_q == '0) begin
					swd_q <= digit;
				end
				if (!digit) begin
					all_digits_q <= 1'b0;
				end
				if (!digit && !is_dot) begin
					dod_q <= 1'b0;
				end
				if (is_dot) begin
					seen_dot_q <= 1'b1;
				end
				if (pending_q != LenW'(LENGTH_LIMIT)) begin
					pending_q <= pending_q + 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept && (push_cmd.tok_valid || push_cmd.op_valid))
		else $error("push without a closing word");
	assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == '0 |-> cand_q == '1 && all_digits_q && dod_q && !seen_dot_q)
		else $error("token state not clear with no pending token");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !closing |=> pending_q != '0)
		else $error("token length did not advance");

endmodule

// ===== rtl/ltc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_queue
// Short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module ltc_queue import ltc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/ltc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_back
// Expands each queued command into one or two result words.
// ----------------------------------------------------------------------------
module ltc_back import ltc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [2:0] kind,
	output logic [4:0] keyword_number,
	output logic [7:0] operator_char,
	output logic [7:0] token_length,
	output logic       last
);

	logic       out_valid_q;
	kind_t      kind_q;
	logic [4:0] kw_q;
	logic [7:0] op_char_q;
	logic [7:0] len_q;
	logic       last_q;
	logic       op_phase_q;

	logic       load;
	logic       emit_tok;

	assign load     = !out_valid_q || !out_stall;
	assign emit_tok = head_cmd.tok_valid && !op_phase_q;
	assign pop      = load && head_valid && !(emit_tok && head_cmd.op_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			op_phase_q  <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				op_phase_q <= emit_tok && head_cmd.op_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			if (emit_tok) begin
				kind_q    <= head_cmd.tok_kind;
				kw_q      <= head_cmd.tok_kw;
				op_char_q <= 8'h00;
				len_q     <= head_cmd.tok_len;
				last_q    <= !head_cmd.op_valid;
			end else begin
				kind_q    <= KIND_OPERATOR;
				kw_q      <= '0;
				op_char_q <= head_cmd.op_char;
				len_q     <= 8'd1;
				last_q    <= 1'b1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign keyword_number = kw_q;
	assign operator_char  = op_char_q;
	assign token_length   = len_q;
	assign last           = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		op_phase_q |-> head_valid && head_cmd.tok_valid && head_cmd.op_valid)
		else $error("operator phase without a two-word command");
	assert property (@(posedge clk) disable iff (!arst_n)
		op_phase_q |-> out_valid_q && !last_q)
		else $error("operator phase without a pending token word");

endmodule

// ===== rtl/lexical_token_classifier_unit.sv =====
`timescale 1ns / 1ps
// A result word passes the command queue and the output register after the closing
// character is accepted. One character per cycle while the queue is not full; one
// result word per cycle while out_stall is low. A character that yields a token and
// an operator gives two words, token then operator; the four-entry command queue absorbs these.
// Reset (arst_n low, asynchronous) clears the token state, queue and output.
// ----------------------------------------------------------------------------
// lexical_token_classifier_unit
// Character-serial lexical scanner that reports tokens and operators.
// ----------------------------------------------------------------------------
module lexical_token_classifier_unit import ltc_pkg::*; #(
	parameter int LENGTH_LIMIT = LENGTH_LIMIT_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] character,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [4:0] keyword_number,
	output logic [7:0] operator_char,
	output logic [7:0] token_length,
	output logic       last
);

	logic push;
	cmd_t push_cmd;
	logic pop;
	logic queue_full;
	logic head_valid;
	cmd_t head_cmd;

	ltc_front #(
		.LENGTH_LIMIT(LENGTH_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.character  (character),
		.end_of_text(end_of_text),
		.queue_full (queue_full),
		.in_stall   (in_stall),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	ltc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (queue_full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	ltc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.kind          (kind),
		.keyword_number(keyword_number),
		.operator_char (operator_char),
		.token_length  (token_length),
		.last          (last)
	);

endmodule
